>>> design/pdd_pkg.sv
// Shared types and constants for the pair difference detector.
package pdd_pkg;

   // Default sizes of the hash table and of one stored value.
   localparam int DEF_CAPACITY   = 1024;
   localparam int DEF_VALUE_BITS = 31;

   // Each table entry carries an epoch tag, so a new array needs no full clear.
   localparam int EPOCH_BITS = 4;
   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEARED = '0;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST   = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST    = '1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_PROBE
   } state_type;

   // The three lookups; the lower one is skipped when the value is below the difference.
   typedef enum logic [1:0] {
      PH_LOWER,
      PH_UPPER,
      PH_OWN
   } phase_type;

   // Status of the slot read in the previous cycle.
   typedef struct packed {
      logic used;
      logic match;
   } probe_type;

endpackage

>>> design/pdd_table.sv
// Hash table memory with epoch-tagged entries and slot compare.
module pdd_table #(
   parameter int CAPACITY   = pdd_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = pdd_pkg::DEF_VALUE_BITS
) (
   input  logic                                     clock,
   input  logic                                     rd_en,
   input  logic [$clog2(CAPACITY)-1:0]              rd_addr,
   input  logic                                     wr_en,
   input  logic [$clog2(CAPACITY)-1:0]              wr_addr,
   input  logic [pdd_pkg::EPOCH_BITS-1:0]           wr_tag,
   input  logic [VALUE_BITS-1:0]                    wr_value,
   input  logic [pdd_pkg::EPOCH_BITS-1:0]           epoch,
   input  logic [VALUE_BITS:0]                      key,
   output pdd_pkg::probe_type                       probe
);
   import pdd_pkg::*;

   localparam int WORD_BITS = EPOCH_BITS + VALUE_BITS;

   logic [WORD_BITS-1:0] mem [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [EPOCH_BITS-1:0] slot_tag;
   logic [VALUE_BITS-1:0] slot_value;

   // Single write port, single read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_tag, wr_value};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // A slot is in use only if it was written during the current epoch.
   assign slot_tag    = rd_data_ff[WORD_BITS-1:VALUE_BITS];
   assign slot_value  = rd_data_ff[VALUE_BITS-1:0];
   assign probe.used  = (slot_tag == epoch);
   assign probe.match = probe.used && ({1'b0, slot_value} == key);

endmodule

>>> design/pdd_ctrl.sv
// Sequencer for lookups, insertion, epoch handling and the clearing pass.
module pdd_ctrl #(
   parameter int CAPACITY   = pdd_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = pdd_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [VALUE_BITS-1:0]                req_value,
   input  logic                                 req_new_array,
   input  logic [VALUE_BITS-1:0]                difference,
   output logic                                 rsp_valid,
   output logic                                 rsp_pair_here,
   output logic                                 rsp_pair_seen,
   output logic                                 rsp_table_full,
   input  pdd_pkg::probe_type                   probe,
   output logic                                 rd_en,
   output logic [$clog2(CAPACITY)-1:0]          rd_addr,
   output logic                                 wr_en,
   output logic [$clog2(CAPACITY)-1:0]          wr_addr,
   output logic [pdd_pkg::EPOCH_BITS-1:0]       wr_tag,
   output logic [VALUE_BITS-1:0]                wr_value,
   output logic [pdd_pkg::EPOCH_BITS-1:0]       epoch,
   output logic [VALUE_BITS:0]                  key
);
   import pdd_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;
   localparam int KW = VALUE_BITS + 1;
   localparam int HB = (KW > AW) ? KW : AW;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [CW-1:0]          probes_ff, probes_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic                   found_ff, found_in;
   logic                   hit_ff, hit_in;
   logic                   pending_ff, pending_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_here_ff, rsp_here_in;
   logic                   rsp_seen_ff, rsp_seen_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic [HB-1:0]          key_ext;
   logic [AW-1:0]          hash_raw;
   logic [AW-1:0]          home_addr;
   logic [AW-1:0]          next_addr;
   logic                   probe_done;

   // Key of the current lookup, one bit wider than a value so it never wraps.
   always_comb begin
      unique case (phase_ff)
         PH_LOWER: key = {1'b0, value_ff} - {1'b0, difference};
         PH_UPPER: key = {1'b0, value_ff} + {1'b0, difference};
         PH_OWN:   key = {1'b0, value_ff};
         default:  key = {1'b0, value_ff};
      endcase
   end

   // Home slot: low key bits, folded once into the table range.
   assign key_ext  = HB'(key);
   assign hash_raw = key_ext[AW-1:0];
   assign home_addr = ({1'b0, hash_raw} >= CAP_COUNT) ?
                      AW'({1'b0, hash_raw} - CAP_COUNT) : hash_raw;

   // Linear probing wraps at the end of the table.
   assign next_addr = (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);

   // A lookup ends on a match, on an unused slot, or after visiting every slot.
   assign probe_done = probe.match || !probe.used || (probes_ff == CAP_COUNT);

   // Next state, memory accesses and result.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      value_in     = value_ff;
      addr_in      = addr_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      epoch_in     = epoch_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      pending_in   = pending_ff;
      rsp_valid_in = 1'b0;
      rsp_here_in  = rsp_here_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_full_in  = rsp_full_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_tag       = epoch_ff;
      wr_value     = value_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the whole table, marking every slot unused.
            wr_en  = 1'b1;
            wr_tag = EPOCH_CLEARED;
            if (addr_ff == LAST_ADDR) begin
               addr_in    = '0;
               epoch_in   = EPOCH_FIRST;
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_ISSUE : ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               phase_in = (req_value >= difference) ? PH_LOWER : PH_UPPER;
               hit_in   = 1'b0;
               state_in = ST_ISSUE;
               if (req_new_array) begin
                  count_in = '0;
                  found_in = 1'b0;
                  // Tags run out: clear the table once, then restart the epochs.
                  if (epoch_ff == EPOCH_LAST) begin
                     state_in   = ST_CLEAR;
                     pending_in = 1'b1;
                     addr_in    = '0;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_BITS'(1);
                  end
               end
            end
         end
         ST_ISSUE: begin
            // Read the home slot of the current key.
            rd_en     = 1'b1;
            rd_addr   = home_addr;
            addr_in   = home_addr;
            probes_in = CW'(1);
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            if (probe_done) begin
               if (phase_ff != PH_OWN) begin
                  hit_in   = hit_ff | probe.match;
                  phase_in = (phase_ff == PH_LOWER) ? PH_UPPER : PH_OWN;
                  state_in = ST_ISSUE;
               end else begin
                  // Own lookup: insert a new value, or report a full table.
                  rsp_valid_in = 1'b1;
                  rsp_here_in  = hit_ff;
                  rsp_seen_in  = found_ff | hit_ff;
                  rsp_full_in  = !probe.match && probe.used;
                  found_in     = found_ff | hit_ff;
                  if (!probe.used) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               rd_en     = 1'b1;
               rd_addr   = next_addr;
               addr_in   = next_addr;
               probes_in = probes_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_OWN;
         addr_ff      <= '0;
         probes_ff    <= '0;
         count_ff     <= '0;
         epoch_ff     <= EPOCH_FIRST;
         found_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         probes_ff    <= probes_in;
         count_ff     <= count_in;
         epoch_ff     <= epoch_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      rsp_here_ff <= rsp_here_in;
      rsp_seen_ff <= rsp_seen_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign epoch          = epoch_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_here  = rsp_here_ff;
   assign rsp_pair_seen  = rsp_seen_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

>>> design/pair_difference_detector_unit.sv
// Top level of the pair difference detector: register, sequencer and table.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_value, req_new_array   start high while busy low
//   response  rsp_valid, rsp_pair_here/seen/full      rsp_valid high, one cycle
//   register  csr_write, csr_difference               csr_write high
//
// An element makes two or three lookups. Each reads its home slot, then further
// slots as needed, one at a time through the single read port of the table. The
// result appears the cycle after the last probe, while the next element may
// already be accepted.
// After reset the table is swept once, with busy high. A new array costs no
// sweep except every fifteenth, which sweeps again.
// The receiver cannot stall: each result is shown for one cycle only.
module pair_difference_detector_unit #(
   parameter int CAPACITY   = pdd_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = pdd_pkg::DEF_VALUE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  logic                   req_new_array,
   output logic                   rsp_valid,
   output logic                   rsp_pair_here,
   output logic                   rsp_pair_seen,
   output logic                   rsp_table_full,
   input  logic                   csr_write,
   input  logic [VALUE_BITS-1:0]  csr_difference
);
   import pdd_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic [VALUE_BITS-1:0]  difference_ff;
   probe_type              probe;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [EPOCH_BITS-1:0]  wr_tag;
   logic [VALUE_BITS-1:0]  wr_value;
   logic [EPOCH_BITS-1:0]  epoch;
   logic [VALUE_BITS:0]    key;

   // Difference register.
   always_ff @(posedge clock) begin
      if (reset) begin
         difference_ff <= '0;
      end else if (csr_write) begin
         difference_ff <= csr_difference;
      end
   end

   pdd_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_new_array  (req_new_array),
      .difference     (difference_ff),
      .rsp_valid      (rsp_valid),
      .rsp_pair_here  (rsp_pair_here),
      .rsp_pair_seen  (rsp_pair_seen),
      .rsp_table_full (rsp_table_full),
      .probe          (probe),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_tag         (wr_tag),
      .wr_value       (wr_value),
      .epoch          (epoch),
      .key            (key)
   );

   pdd_table #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_table (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_value (wr_value),
      .epoch    (epoch),
      .key      (key),
      .probe    (probe)
   );

endmodule

>>> tb/sv/pair_difference_detector_unit_tb.sv
// Testbench for the pair difference detector: predictor scoreboard and stimulus.
`timescale 1ns / 100ps

module pair_difference_detector_unit_tb;

   import pdd_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int VB  = DEF_VALUE_BITS;
   localparam logic [VB-1:0] VALUE_MAX = '1;

   // Predicts the flags of every element and checks them in order.
   class pair_book;
      typedef struct packed {
         logic here;
         logic seen;
         logic full;
      } verdict_t;

      bit [VB-1:0] diff;
      bit          members[bit [VB:0]];
      bit          found;
      verdict_t    expected_verdicts[$];
      int          errors;
      int          checked;

      // Count one mismatch and print it, up to a sane number of lines.
      task report(string msg);
         if (errors < 40) begin
            $display("mismatch: %s", msg);
         end
         errors++;
      endtask

      function int pending();
         return expected_verdicts.size();
      endfunction

      // An accepted element: clear on a new array, look up the neighbors, then store it if new and there is room.
      function void note_element(bit [VB-1:0] v, bit fresh);
         bit [VB:0] own;
         bit [VB:0] lower;
         bit [VB:0] upper;
         verdict_t  vd;
         if (fresh) begin
            members.delete();
            found = 0;
         end
         own   = {1'b0, v};
         upper = own + {1'b0, diff};
         vd    = '0;
         if (v >= diff) begin
            lower = own - {1'b0, diff};
            if (members.exists(lower)) vd.here = 1;
         end
         if (members.exists(upper)) vd.here = 1;
         if (!members.exists(own)) begin
            if (members.num() < CAP) members[own] = 1;
            else vd.full = 1;
         end
         if (vd.here) found = 1;
         vd.seen = found;
         expected_verdicts.push_back(vd);
      endfunction

      // A result transfer: compare it with the oldest expectation.
      task check_verdict(logic here, logic seen, logic full);
         verdict_t want;
         if (expected_verdicts.size() == 0) begin
            report($sformatf("result %b%b%b with no element pending", here, seen, full));
            return;
         end
         want = expected_verdicts.pop_front();
         if ({here, seen, full} !== want) begin
            report($sformatf("element %0d: here/seen/full got %b%b%b, expected %b%b%b",
                             checked, here, seen, full, want.here, want.seen, want.full));
         end
         checked++;
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [VB-1:0] req_value;
   logic          req_new_array;
   logic          rsp_valid;
   logic          rsp_pair_here;
   logic          rsp_pair_seen;
   logic          rsp_table_full;
   logic          csr_write;
   logic [VB-1:0] csr_difference;

   pair_book book = new();

   pair_difference_detector_unit #(
      .CAPACITY   (CAP),
      .VALUE_BITS (VB)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_new_array  (req_new_array),
      .rsp_valid      (rsp_valid),
      .rsp_pair_here  (rsp_pair_here),
      .rsp_pair_seen  (rsp_pair_seen),
      .rsp_table_full (rsp_table_full),
      .csr_write      (csr_write),
      .csr_difference (csr_difference)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Results are taken at the edge that ends their one valid cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         book.check_verdict(rsp_pair_here, rsp_pair_seen, rsp_table_full);
      end
   end

   // Hold the request until a rising edge sees busy low.
   task send_element(bit [VB-1:0] v, bit fresh);
      @(negedge clock);
      start         = 1;
      req_value     = v;
      req_new_array = fresh;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.note_element(v, fresh);
   endtask

   // With the given chance, drop the request line for a random gap with random data on it.
   task maybe_idle(int pct);
      int gap;
      if ($urandom_range(99) < pct) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         start         = 0;
         req_value     = VB'($urandom);
         req_new_array = 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task wait_drained();
      while (book.pending() != 0) @(posedge clock);
   endtask

   // Change the difference only once the block has finished all work.
   task write_difference(bit [VB-1:0] d);
      @(negedge clock);
      start = 0;
      wait_drained();
      @(negedge clock);
      while (busy) @(negedge clock);
      csr_write      = 1;
      csr_difference = d;
      book.diff      = d;
      @(negedge clock);
      csr_write = 0;
   endtask

   // Random arrays: mostly runs of values spaced by multiples of the difference.
   task run_arrays(int count, int pct);
      int          left;
      int          len;
      bit [VB-1:0] base;
      bit [VB-1:0] last;
      bit [VB-1:0] v;
      longint unsigned wide;
      left = count;
      last = 0;
      while (left > 0) begin
         len  = ($urandom_range(3) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 20);
         base = VB'($urandom);
         for (int i = 0; i < len && left > 0; i++) begin
            case ($urandom_range(9))
               7: v = VB'($urandom);
               8: v = last;
               9: v = VALUE_MAX - VB'($urandom_range(0, 3)) * book.diff;
               default: begin
                  wide = base + longint'($urandom_range(0, 7)) * book.diff;
                  v    = wide[VB-1:0];
               end
            endcase
            maybe_idle(pct);
            send_element(v, i == 0);
            last = v;
            left--;
         end
      end
   endtask

   // One array that overflows the table, then repeats, hits and more misses.
   task fill_table(int pct);
      bit [VB-1:0] kept[$];
      bit [VB-1:0] v;
      for (int i = 0; i < CAP + 6; i++) begin
         v = VB'($urandom);
         kept.push_back(v);
         maybe_idle(pct);
         send_element(v, i == 0);
      end
      for (int i = 0; i < 12; i++) begin
         case (i % 3)
            0: v = kept[$urandom_range(0, CAP - 1)];
            1: v = kept[$urandom_range(0, CAP - 1)] + book.diff;
            default: v = VB'($urandom);
         endcase
         maybe_idle(pct);
         send_element(v, 0);
      end
   endtask

   // Run limit, far above the slowest correct run.
   initial begin
      #200_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int pcts[3];
      bit [VB-1:0] d;
      pcts = '{0, 62, 10};
      reset          = 1;
      start          = 0;
      req_value      = 0;
      req_new_array  = 0;
      csr_write      = 0;
      csr_difference = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Zero difference: equal values pair, extremes of the value range.
      write_difference(0);
      send_element(5, 1);
      send_element(5, 0);
      send_element(0, 0);
      send_element(VALUE_MAX, 0);
      send_element(VALUE_MAX, 0);

      // Largest difference: only zero and the largest value pair.
      write_difference(VALUE_MAX);
      send_element(0, 1);
      send_element(VALUE_MAX, 0);
      send_element(0, 0);

      // Difference above the value, and a new array clearing the sticky flag.
      write_difference(100);
      send_element(50, 1);
      send_element(150, 0);
      send_element(250, 0);
      send_element(200, 1);
      send_element(100, 0);
      send_element(300, 0);

      // Unit difference at both ends of the range.
      write_difference(1);
      send_element(VALUE_MAX - 1, 1);
      send_element(VALUE_MAX, 0);
      send_element(1, 1);
      send_element(0, 0);

      // Random phases over several differences and idle rates.
      for (int p = 0; p < 8; p++) begin
         case (p % 5)
            0: d = 0;
            1: d = VB'($urandom_range(1, 64));
            2: d = VALUE_MAX;
            3: d = VB'($urandom);
            default: d = 1;
         endcase
         write_difference(d);
         run_arrays(90, pcts[p % 3]);
      end

      // Overflow of the table.
      write_difference(VB'($urandom_range(1, 1 << 20)));
      fill_table(10);

      @(negedge clock);
      start = 0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (book.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/pdd_pkg.sv
design/pdd_table.sv
design/pdd_ctrl.sv
design/pair_difference_detector_unit.sv
tb/sv/pair_difference_detector_unit_tb.sv
